>>> sv/cctm_pkg.sv
package cctm_pkg;

    localparam int NUM_CHANNELS = 7;
    localparam int COUNT_BITS   = 16;

    // width of a channel number on the ports, and the slots it can name
    localparam int CH_FIELD_W = 3;
    localparam int CH_SLOTS   = 2 ** CH_FIELD_W;

    // index width for the channel arrays
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [CH_FIELD_W-1:0] NO_CHANNEL = CH_FIELD_W'(CH_SLOTS - 1);
    localparam logic [CH_FIELD_W-1:0] FIRST_FREE_RESET = CH_FIELD_W'(2);

    localparam int ERR_CREATE  = 0;
    localparam int ERR_RELEASE = 1;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_TAKE    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_ADJUST  = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        KIND_TAKE    = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_ADJUST  = 2'd2,
        KIND_FIRE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_SCAN = 2'd2
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;     // latch the input transaction
        logic exec_tick;  // advance counter, capture channel matches
        logic exec_op;    // run take / release / adjust and load its reply
        logic fire;       // serve the lowest pending fire
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic any_hit;
        logic pend_any;
        logic last_hit;
        logic out_free;
    } t_dp_stat;

endpackage

>>> sv/cctm_ctrl.sv
module cctm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  cctm_pkg::t_dp_stat i_stat,
    output cctm_pkg::t_dp_cmd  o_cmd,
    output logic               o_in_stall
);

    cctm_pkg::t_state r_state;
    cctm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cctm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cctm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = cctm_pkg::ST_EXEC;
                end
            end
            cctm_pkg::ST_EXEC: begin
                if (i_stat.is_tick) begin
                    n_state = i_stat.any_hit ? cctm_pkg::ST_SCAN : cctm_pkg::ST_IDLE;
                end else if (i_stat.out_free) begin
                    n_state = cctm_pkg::ST_IDLE;
                end
            end
            cctm_pkg::ST_SCAN: begin
                if (i_stat.out_free && i_stat.last_hit) begin
                    n_state = cctm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cctm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            cctm_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            cctm_pkg::ST_EXEC: begin
                o_cmd.exec_tick = i_stat.is_tick;
                o_cmd.exec_op   = !i_stat.is_tick && i_stat.out_free;
            end
            cctm_pkg::ST_SCAN: begin
                o_cmd.fire = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/cctm_dp.sv
module cctm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cctm_pkg::t_dp_cmd                   i_cmd_ctl,
    output cctm_pkg::t_dp_stat                  o_stat,
    input  logic                                i_cfg_we,
    input  logic [cctm_pkg::CH_FIELD_W-1:0]     i_cfg_data,
    input  logic [1:0]                          i_cmd,
    input  logic [cctm_pkg::CH_FIELD_W-1:0]     i_channel,
    input  logic                                i_pick_any,
    input  logic [15:0]                         i_interval,
    input  logic                                i_single_shot,
    input  logic [15:0]                         i_adjust_amount,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [1:0]                          o_kind,
    output logic [cctm_pkg::CH_FIELD_W-1:0]     o_result_channel,
    output logic                                o_ok,
    output logic [1:0]                          o_error_flags,
    output logic                                o_last
);

    localparam int N  = cctm_pkg::NUM_CHANNELS;
    localparam int CB = cctm_pkg::COUNT_BITS;
    localparam int CW = cctm_pkg::CH_W;
    localparam int FW = cctm_pkg::CH_FIELD_W;

    // latched transaction
    cctm_pkg::t_cmd_code r_cmd;
    logic [FW-1:0]       r_ch;
    logic                r_pick;
    logic [15:0]         r_interval;
    logic                r_single;
    logic [15:0]         r_amount;

    // control state
    logic [CB-1:0] r_cnt;
    logic [N-1:0]  r_busy;
    logic [N-1:0]  n_busy;
    logic [N-1:0]  r_pend;
    logic [N-1:0]  n_pend;
    logic [1:0]    r_err;
    logic [1:0]    n_err;
    logic [FW-1:0] r_ffc;

    // channel store
    logic [CB-1:0] r_cmp [N];
    logic [CB-1:0] r_per [N];
    logic          r_one [N];

    // output register
    logic                r_out_valid;
    cctm_pkg::t_kind     r_kind;
    logic [FW-1:0]       r_rch;
    logic                r_ok;
    logic [1:0]          r_oerr;
    logic                r_last;
    cctm_pkg::t_kind     n_kind;
    logic [FW-1:0]       n_rch;
    logic                n_ok;
    logic                n_last;
    logic                load_out;

    logic [CB-1:0]            cnt_inc;
    logic [N-1:0]             hit;
    logic [cctm_pkg::CH_SLOTS-1:0] busy_ext;
    logic                     ch_ok;
    logic                     pick_found;
    logic [CW-1:0]            pick_idx;
    logic                     take_ok;
    logic [CW-1:0]            take_idx;
    logic                     adj_ok;
    logic [CW-1:0]            fire_idx;
    logic [N-1:0]             fire_bit;
    logic [CW-1:0]            rd_idx;
    logic [CB-1:0]            rd_cmp;
    logic [CB-1:0]            rd_per;
    logic                     rd_one;
    logic                     wr_en;
    logic                     wr_full;
    logic [CW-1:0]            wr_idx;
    logic [CB-1:0]            wr_cmp;

    assign cnt_inc  = r_cnt + CB'(1);
    assign busy_ext = cctm_pkg::CH_SLOTS'(r_busy);
    assign ch_ok    = r_ch < FW'(N);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            hit[i] = r_busy[i] && (r_cmp[i] == cnt_inc);
        end
    end

    // lowest free channel at or above the configured floor
    always_comb begin
        pick_found = 1'b0;
        pick_idx   = '0;
        for (int i = 0; i < N; i++) begin
            if (!pick_found && !r_busy[i] && (FW'(i) >= r_ffc)) begin
                pick_found = 1'b1;
                pick_idx   = CW'(i);
            end
        end
    end

    // lowest pending fire
    always_comb begin
        fire_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                fire_idx = CW'(i);
            end
        end
        fire_bit = N'(1) << fire_idx;
    end

    assign take_ok  = r_pick ? pick_found : (ch_ok && !busy_ext[r_ch]);
    assign take_idx = r_pick ? pick_idx : r_ch[CW-1:0];
    assign adj_ok   = ch_ok && busy_ext[r_ch];

    assign rd_idx = i_cmd_ctl.fire ? fire_idx : r_ch[CW-1:0];
    assign rd_cmp = r_cmp[rd_idx];
    assign rd_per = r_per[rd_idx];
    assign rd_one = r_one[rd_idx];

    always_comb begin
        wr_en    = 1'b0;
        wr_full  = 1'b0;
        wr_idx   = take_idx;
        wr_cmp   = rd_cmp;
        n_busy   = r_busy;
        n_pend   = r_pend;
        n_err    = r_err;
        n_kind   = cctm_pkg::KIND_FIRE;
        n_rch    = r_ch;
        n_ok     = 1'b1;
        n_last   = 1'b1;
        load_out = 1'b0;
        if (i_cmd_ctl.exec_tick) begin
            n_pend = hit;
        end
        if (i_cmd_ctl.exec_op) begin
            load_out = 1'b1;
            unique case (r_cmd)
                cctm_pkg::CMD_TAKE: begin
                    n_kind = cctm_pkg::KIND_TAKE;
                    if (take_ok) begin
                        wr_en            = 1'b1;
                        wr_full          = 1'b1;
                        wr_cmp           = r_cnt + CB'(r_interval);
                        n_busy[take_idx] = 1'b1;
                        n_rch            = FW'(take_idx);
                    end else begin
                        n_err[cctm_pkg::ERR_CREATE] = 1'b1;
                        n_rch = cctm_pkg::NO_CHANNEL;
                        n_ok  = 1'b0;
                    end
                end
                cctm_pkg::CMD_RELEASE: begin
                    n_kind = cctm_pkg::KIND_RELEASE;
                    if (ch_ok) begin
                        n_busy[r_ch[CW-1:0]] = 1'b0;
                    end else begin
                        n_err[cctm_pkg::ERR_RELEASE] = 1'b1;
                        n_ok = 1'b0;
                    end
                end
                cctm_pkg::CMD_ADJUST: begin
                    n_kind = cctm_pkg::KIND_ADJUST;
                    n_ok   = adj_ok;
                    if (adj_ok) begin
                        wr_en  = 1'b1;
                        wr_idx = r_ch[CW-1:0];
                        wr_cmp = rd_cmp + CB'(r_amount);
                    end
                end
                default: begin
                    load_out = 1'b0;
                end
            endcase
        end
        if (i_cmd_ctl.fire) begin
            load_out = 1'b1;
            wr_en    = 1'b1;
            wr_idx   = fire_idx;
            wr_cmp   = rd_cmp + rd_per;
            n_pend   = r_pend & ~fire_bit;
            n_last   = (r_pend & ~fire_bit) == '0;
            n_kind   = cctm_pkg::KIND_FIRE;
            n_rch    = FW'(fire_idx);
            if (rd_one) begin
                n_busy[fire_idx] = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_busy      <= '0;
            r_pend      <= '0;
            r_err       <= '0;
            r_ffc       <= cctm_pkg::FIRST_FREE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd_ctl.exec_tick) begin
                r_cnt <= cnt_inc;
            end
            if (i_cfg_we) begin
                r_ffc <= i_cfg_data;
            end
            r_busy <= n_busy;
            r_pend <= n_pend;
            r_err  <= n_err;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.accept) begin
            r_cmd      <= cctm_pkg::t_cmd_code'(i_cmd);
            r_ch       <= i_channel;
            r_pick     <= i_pick_any;
            r_interval <= i_interval;
            r_single   <= i_single_shot;
            r_amount   <= i_adjust_amount;
        end
        if (wr_en) begin
            r_cmp[wr_idx] <= wr_cmp;
        end
        if (wr_full) begin
            r_per[wr_idx] <= CB'(r_interval);
            r_one[wr_idx] <= r_single;
        end
        if (load_out) begin
            r_kind <= n_kind;
            r_rch  <= n_rch;
            r_ok   <= n_ok;
            r_oerr <= n_err;
            r_last <= n_last;
        end
    end

    assign o_stat.is_tick  = r_cmd == cctm_pkg::CMD_TICK;
    assign o_stat.any_hit  = |hit;
    assign o_stat.pend_any = |r_pend;
    assign o_stat.last_hit = (r_pend & ~fire_bit) == '0;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_result_channel = r_rch;
    assign o_ok             = r_ok;
    assign o_error_flags    = r_oerr;
    assign o_last           = r_last;

endmodule

>>> sv/compare_channel_timer_manager.sv
// take, release and adjust: the transaction is latched, then its reply is registered once the
//   output is free; the next transaction is taken only after that reply is loaded
// tick: the counter advances and all channels are matched at once, then one fire per
//   cycle while the output is not stalled, through the shared compare reload adder
// output register decouples the sides; a held result only stalls the next emit
// synchronous active-low reset: counter, busy bits and sticky errors clear, floor = 2
module compare_channel_timer_manager (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration: first channel automatic allocation may hand out
    input  logic                            i_cfg_we,
    input  logic [cctm_pkg::CH_FIELD_W-1:0] i_cfg_data,
    // command transaction
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_cmd,
    input  logic [cctm_pkg::CH_FIELD_W-1:0] i_channel,
    input  logic                            i_pick_any,
    input  logic [15:0]                     i_interval,
    input  logic                            i_single_shot,
    input  logic [15:0]                     i_adjust_amount,
    // result transaction
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_kind,
    output logic [cctm_pkg::CH_FIELD_W-1:0] o_result_channel,
    output logic                            o_ok,
    output logic [1:0]                      o_error_flags,
    output logic                            o_last
);

    cctm_pkg::t_dp_cmd  s_cmd;
    cctm_pkg::t_dp_stat s_stat;

    // sequencer: idle / execute / fire scan
    cctm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd),
        .o_in_stall (o_in_stall)
    );

    // counter, channel store, allocation search, result register
    cctm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_ctl        (s_cmd),
        .o_stat           (s_stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (i_cmd),
        .i_channel        (i_channel),
        .i_pick_any       (i_pick_any),
        .i_interval       (i_interval),
        .i_single_shot    (i_single_shot),
        .i_adjust_amount  (i_adjust_amount),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_kind           (o_kind),
        .o_result_channel (o_result_channel),
        .o_ok             (o_ok),
        .o_error_flags    (o_error_flags),
        .o_last           (o_last)
    );

`ifndef SYNTHESIS
    // once a transaction is taken the block is busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.accept |=> o_in_stall)
        else $error("input not stalled after accepting a transaction");

    // a fire step always has a matched channel to serve
    a_fire_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.fire |-> s_stat.pend_any)
        else $error("fire step with no pending channel");

    // a new result never overwrites one the receiver is still holding off
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.exec_op || s_cmd.fire) |-> (!o_out_valid || !i_out_stall))
        else $error("result register loaded while stalled");
`endif

endmodule
